// ===== hdl/mchw_pkg.sv =====
// ----------------------------------------------------------------------------
// mchw_pkg
// Shared types and constants for the multi-channel heartbeat watchdog:
// register map, reset values, operation codes and the configuration bundle.
// ----------------------------------------------------------------------------
package mchw_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  // Register index, taken from paddr[2] (registers sit 4 bytes apart).
  typedef enum logic {
    REG_HEARTBEAT_TIMEOUT  = 1'b0,
    REG_RESPONDER_LIFETIME = 1'b1
  } reg_idx_t;

  typedef enum logic {
    OP_KICK  = 1'b0,
    OP_CHECK = 1'b1
  } op_t;

  localparam logic [TIME_W-1:0] HEARTBEAT_TIMEOUT_RST  = 32'd2000;
  localparam logic [TIME_W-1:0] RESPONDER_LIFETIME_RST = 32'd10000;

  typedef struct packed {
    logic [TIME_W-1:0] heartbeat_timeout_ms;
    logic [TIME_W-1:0] responder_lifetime_ms;
  } cfg_t;

endpackage

// ===== hdl/multi_channel_heartbeat_watchdog.sv =====
// ----------------------------------------------------------------------------
// multi_channel_heartbeat_watchdog
// Heartbeat, monitor-liveness and responder-lifetime watchdog with an APB
// configuration port and valid/ready item and result channels.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one transaction per item. op = kick stores now_ms
//   for in_channel; op = check tests all monitors, heartbeat channels and
//   responders against the stored times and the configured limits.
//   Result channel (out_*): exactly one transaction per input item, in order;
//   a kick returns all-zero fields.
//   APB port: register 0 (addr 0) heartbeat timeout, register 1 (addr 4)
//   responder lifetime, both in ms. Write only while the block is idle.
// Pipeline and throughput:
//   An item passes the input register, then the result register; out_valid
//   rises when the item is written into the result register.
//   One item per cycle sustained while out_ready stays high; the compare logic
//   sits in a single stage and the timestamp state commits as each item leaves
//   the input register, so the next item sees it immediately.
// Reset:
//   rst_n (synchronous) clears both stages, all heartbeat and spawn times
//   (channels unarmed, responders untracked) and reloads default limits.
// Stall:
//   When out_ready is low the result holds; the input register still fills,
//   then in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module multi_channel_heartbeat_watchdog #(
  parameter int unsigned HEARTBEAT_CHANNELS = 3,
  parameter int unsigned MONITOR_CHANNELS   = 3,
  parameter int unsigned RESPONDER_CHANNELS = 4,
  localparam int unsigned CHAN_W = (HEARTBEAT_CHANNELS > 1) ?
                                   $clog2(HEARTBEAT_CHANNELS) : 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // item channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_op,
  input  logic [CHAN_W-1:0]               in_channel,
  input  logic [mchw_pkg::TIME_W-1:0]     in_now_ms,
  input  logic [MONITOR_CHANNELS-1:0]     in_monitors_alive,
  input  logic [RESPONDER_CHANNELS-1:0]   in_responders_present,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [MONITOR_CHANNELS-1:0]     out_monitor_restart,
  output logic [HEARTBEAT_CHANNELS-1:0]   out_heartbeat_alert,
  output logic [RESPONDER_CHANNELS-1:0]   out_responder_kill,
  output logic                            out_frozen_event,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mchw_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [mchw_pkg::APB_DATA_W-1:0] pwdata,
  output logic [mchw_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  mchw_pkg::cfg_t cfg;

  // Input stage
  logic                            s1_valid_r;
  mchw_pkg::op_t                   s1_op_r;
  logic [CHAN_W-1:0]               s1_channel_r;
  logic [mchw_pkg::TIME_W-1:0]     s1_now_r;
  logic [MONITOR_CHANNELS-1:0]     s1_alive_r;
  logic [RESPONDER_CHANNELS-1:0]   s1_present_r;

  // Result stage
  logic                            out_valid_r;
  logic [MONITOR_CHANNELS-1:0]     restart_r;
  logic [HEARTBEAT_CHANNELS-1:0]   alert_r;
  logic [RESPONDER_CHANNELS-1:0]   kill_r;
  logic                            frozen_r;

  logic [MONITOR_CHANNELS-1:0]     restart_nxt;
  logic [HEARTBEAT_CHANNELS-1:0]   alert_nxt;
  logic [RESPONDER_CHANNELS-1:0]   kill_nxt;

  logic s1_adv;
  logic in_take;

  // Advance the staged item whenever the result register is free or draining.
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_take  = in_valid && in_ready;

  mchw_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mchw_check #(
    .HEARTBEAT_CHANNELS (HEARTBEAT_CHANNELS),
    .MONITOR_CHANNELS   (MONITOR_CHANNELS),
    .RESPONDER_CHANNELS (RESPONDER_CHANNELS),
    .CHAN_W             (CHAN_W)
  ) u_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .advance            (s1_adv),
    .op                 (s1_op_r),
    .channel            (s1_channel_r),
    .now_ms             (s1_now_r),
    .monitors_alive     (s1_alive_r),
    .responders_present (s1_present_r),
    .cfg                (cfg),
    .monitor_restart    (restart_nxt),
    .heartbeat_alert    (alert_nxt),
    .responder_kill     (kill_nxt)
  );

  // Control: hold valid flags until the stage moves on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: capture on transaction, no reset needed.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r      <= mchw_pkg::op_t'(in_op);
      s1_channel_r <= in_channel;
      s1_now_r     <= in_now_ms;
      s1_alive_r   <= in_monitors_alive;
      s1_present_r <= in_responders_present;
    end
    if (s1_adv) begin
      restart_r <= restart_nxt;
      alert_r   <= alert_nxt;
      kill_r    <= kill_nxt;
      frozen_r  <= (|restart_nxt) | (|alert_nxt) | (|kill_nxt);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_monitor_restart = restart_r;
  assign out_heartbeat_alert = alert_r;
  assign out_responder_kill  = kill_r;
  assign out_frozen_event    = frozen_r;

`ifndef NO_ASSERTIONS
  // Frozen flag must match the alert fields it summarizes.
  a_frozen_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frozen_event ==
                   ((|out_monitor_restart) | (|out_heartbeat_alert) |
                    (|out_responder_kill))))
    else $error("frozen_event disagrees with alert fields");

  // A kick must produce an all-zero result.
  a_kick_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_op_r == mchw_pkg::OP_KICK) |=>
      (out_monitor_restart == '0 && out_heartbeat_alert == '0 &&
       out_responder_kill == '0 && !out_frozen_event))
    else $error("kick produced a nonzero result");

  // An empty result register must never block the input side.
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty result register");

  // A staged item blocked by a held result must still be staged next cycle.
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ready) |=> (s1_valid_r && out_valid_r))
    else $error("staged item lost during output stall");
`endif

endmodule

// ===== hdl/mchw_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// mchw_cfg_regs
// APB register file holding the heartbeat timeout and the responder lifetime.
// ----------------------------------------------------------------------------
module mchw_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mchw_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [mchw_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [mchw_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output mchw_pkg::cfg_t                      cfg
);

  mchw_pkg::cfg_t   cfg_r;
  mchw_pkg::reg_idx_t reg_idx;
  logic             wr_en;

  assign pready  = 1'b1;
  assign reg_idx = mchw_pkg::reg_idx_t'(paddr[2]);
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.heartbeat_timeout_ms  <= mchw_pkg::HEARTBEAT_TIMEOUT_RST;
      cfg_r.responder_lifetime_ms <= mchw_pkg::RESPONDER_LIFETIME_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        mchw_pkg::REG_HEARTBEAT_TIMEOUT:  cfg_r.heartbeat_timeout_ms  <= pwdata;
        mchw_pkg::REG_RESPONDER_LIFETIME: cfg_r.responder_lifetime_ms <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mchw_pkg::REG_HEARTBEAT_TIMEOUT:  prdata = cfg_r.heartbeat_timeout_ms;
      mchw_pkg::REG_RESPONDER_LIFETIME: prdata = cfg_r.responder_lifetime_ms;
      default:                          prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/mchw_check.sv =====
// ----------------------------------------------------------------------------
// mchw_check
// Timestamp state and per-channel compare logic. Evaluates the staged item
// against stored times and commits the state update when the item advances.
// ----------------------------------------------------------------------------
module mchw_check #(
  parameter int unsigned HEARTBEAT_CHANNELS = 3,
  parameter int unsigned MONITOR_CHANNELS   = 3,
  parameter int unsigned RESPONDER_CHANNELS = 4,
  parameter int unsigned CHAN_W             = 2
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              advance,
  input  mchw_pkg::op_t                     op,
  input  logic [CHAN_W-1:0]                 channel,
  input  logic [mchw_pkg::TIME_W-1:0]       now_ms,
  input  logic [MONITOR_CHANNELS-1:0]       monitors_alive,
  input  logic [RESPONDER_CHANNELS-1:0]     responders_present,
  input  mchw_pkg::cfg_t                    cfg,
  output logic [MONITOR_CHANNELS-1:0]       monitor_restart,
  output logic [HEARTBEAT_CHANNELS-1:0]     heartbeat_alert,
  output logic [RESPONDER_CHANNELS-1:0]     responder_kill
);

  logic [mchw_pkg::TIME_W-1:0] hb_time_r   [HEARTBEAT_CHANNELS];
  logic [mchw_pkg::TIME_W-1:0] hb_time_nxt [HEARTBEAT_CHANNELS];
  logic [mchw_pkg::TIME_W-1:0] spawn_r     [RESPONDER_CHANNELS];
  logic [mchw_pkg::TIME_W-1:0] spawn_nxt   [RESPONDER_CHANNELS];
  logic                        is_check;

  assign is_check        = (op == mchw_pkg::OP_CHECK);
  assign monitor_restart = is_check ? ~monitors_alive : '0;

  for (genvar i = 0; i < HEARTBEAT_CHANNELS; i++) begin : g_hb
    logic [mchw_pkg::TIME_W-1:0] gap;
    logic                        expired;
    assign gap     = now_ms - hb_time_r[i];
    assign expired = is_check && (hb_time_r[i] != '0) &&
                     (gap > cfg.heartbeat_timeout_ms);
    assign heartbeat_alert[i] = expired;
    // Kick stores now for the addressed channel; an alert rearms at now.
    assign hb_time_nxt[i] = ((!is_check && channel == CHAN_W'(i)) || expired) ?
                            now_ms : hb_time_r[i];
  end

  for (genvar i = 0; i < RESPONDER_CHANNELS; i++) begin : g_rsp
    logic [mchw_pkg::TIME_W-1:0] spawn_eff;
    logic [mchw_pkg::TIME_W-1:0] age;
    logic                        too_old;
    // Latch spawn time on first sight; a fresh spawn has age zero.
    assign spawn_eff = (spawn_r[i] == '0) ? now_ms : spawn_r[i];
    assign age       = now_ms - spawn_eff;
    assign too_old   = is_check && responders_present[i] && (spawn_eff != '0) &&
                       (age > cfg.responder_lifetime_ms);
    assign responder_kill[i] = too_old;
    always_comb begin
      if (!is_check) begin
        spawn_nxt[i] = spawn_r[i];
      end else if (!responders_present[i] || too_old) begin
        spawn_nxt[i] = '0;
      end else begin
        spawn_nxt[i] = spawn_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HEARTBEAT_CHANNELS; i++) hb_time_r[i] <= '0;
      for (int i = 0; i < RESPONDER_CHANNELS; i++) spawn_r[i]   <= '0;
    end else if (advance) begin
      for (int i = 0; i < HEARTBEAT_CHANNELS; i++) hb_time_r[i] <= hb_time_nxt[i];
      for (int i = 0; i < RESPONDER_CHANNELS; i++) spawn_r[i]   <= spawn_nxt[i];
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top - heartbeat watchdog regression bench
// Drives kick and check transactions into the watchdog under several limit
// settings and idling mixes. A scoreboard class holds its own copy of the
// heartbeat and spawn timestamps, predicts every result transaction and
// compares it field by field, in order, against what the block returns.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HB_CHANNELS  = 3;
  localparam int unsigned MON_CHANNELS = 3;
  localparam int unsigned RSP_CHANNELS = 4;
  localparam int unsigned QUIET_LIMIT  = 4000;  // cycles with no transaction at all
  localparam int unsigned DRAIN_CYCLES = 6;     // two-stage pipe plus margin
  localparam int unsigned HOLD_CYCLES  = 300;

  // One result transaction, packed in port order.
  typedef struct packed {
    logic [MON_CHANNELS-1:0] restart_mask;
    logic [HB_CHANNELS-1:0]  alert_mask;
    logic [RSP_CHANNELS-1:0] kill_mask;
    logic                    frozen;
  } verdict_t;

  // Scoreboard: mirrors the timestamp state and queues predicted verdicts.
  class heartbeat_verdicts;
    logic [mchw_pkg::TIME_W-1:0] timeout_ms;
    logic [mchw_pkg::TIME_W-1:0] lifetime_ms;
    logic [mchw_pkg::TIME_W-1:0] beat_stamp [HB_CHANNELS];
    logic [mchw_pkg::TIME_W-1:0] spawn_stamp [RSP_CHANNELS];
    verdict_t          pending_verdicts [$];
    int errors, items, kicks, checks, alerts, kills, restarts;

    function new();
      timeout_ms  = mchw_pkg::HEARTBEAT_TIMEOUT_RST;
      lifetime_ms = mchw_pkg::RESPONDER_LIFETIME_RST;
      foreach (beat_stamp[i]) beat_stamp[i] = '0;
      foreach (spawn_stamp[i]) spawn_stamp[i] = '0;
    endfunction

    function void set_limit(mchw_pkg::reg_idx_t idx, logic [mchw_pkg::TIME_W-1:0] value);
      if (idx == mchw_pkg::REG_HEARTBEAT_TIMEOUT) timeout_ms = value;
      else lifetime_ms = value;
    endfunction

    function int pending();
      return pending_verdicts.size();
    endfunction

    function void note_item(mchw_pkg::op_t op, logic [1:0] ch,
                            logic [mchw_pkg::TIME_W-1:0] now,
                            logic [MON_CHANNELS-1:0] alive,
                            logic [RSP_CHANNELS-1:0] present);
      verdict_t                    v;
      logic [mchw_pkg::TIME_W-1:0] gap;
      v = '0;
      items++;
      if (op == mchw_pkg::OP_KICK) begin
        kicks++;
        // An out-of-range channel stores nothing; a stamp of zero means unarmed.
        if (ch < HB_CHANNELS) beat_stamp[ch] = now;
      end else begin
        checks++;
        for (int i = 0; i < MON_CHANNELS; i++) begin
          if (!alive[i]) v.restart_mask[i] = 1'b1;
        end
        for (int i = 0; i < HB_CHANNELS; i++) begin
          gap = now - beat_stamp[i];
          if (beat_stamp[i] != '0 && gap > timeout_ms) begin
            v.alert_mask[i] = 1'b1;
            beat_stamp[i]   = now;
          end
        end
        for (int i = 0; i < RSP_CHANNELS; i++) begin
          if (!present[i]) begin
            spawn_stamp[i] = '0;
          end else begin
            if (spawn_stamp[i] == '0) spawn_stamp[i] = now;
            gap = now - spawn_stamp[i];
            if (spawn_stamp[i] != '0 && gap > lifetime_ms) begin
              v.kill_mask[i] = 1'b1;
              spawn_stamp[i] = '0;
            end
          end
        end
      end
      v.frozen = |{v.restart_mask, v.alert_mask, v.kill_mask};
      alerts   += $countones(v.alert_mask);
      kills    += $countones(v.kill_mask);
      restarts += $countones(v.restart_mask);
      pending_verdicts.push_back(v);
    endfunction

    function void check_result(verdict_t got);
      verdict_t want;
      if (pending_verdicts.size() == 0) begin
        $error("result transaction with nothing expected: %h", got);
        errors++;
        return;
      end
      want = pending_verdicts.pop_front();
      if (got.restart_mask !== want.restart_mask) begin
        $error("monitor_restart mismatch: expected %h, actual %h",
               want.restart_mask, got.restart_mask);
        errors++;
      end
      if (got.alert_mask !== want.alert_mask) begin
        $error("heartbeat_alert mismatch: expected %h, actual %h",
               want.alert_mask, got.alert_mask);
        errors++;
      end
      if (got.kill_mask !== want.kill_mask) begin
        $error("responder_kill mismatch: expected %h, actual %h",
               want.kill_mask, got.kill_mask);
        errors++;
      end
      if (got.frozen !== want.frozen) begin
        $error("frozen_event mismatch: expected %b, actual %b", want.frozen, got.frozen);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block ports; every input starts at a known value.
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                        in_valid              = 1'b0;
  logic                        in_ready;
  logic                        in_op                 = 1'b0;
  logic [1:0]                  in_channel            = '0;
  logic [mchw_pkg::TIME_W-1:0] in_now_ms             = '0;
  logic [MON_CHANNELS-1:0]     in_monitors_alive     = '0;
  logic [RSP_CHANNELS-1:0]     in_responders_present = '0;

  logic                    out_valid;
  logic                    out_ready             = 1'b0;
  logic [MON_CHANNELS-1:0] out_monitor_restart;
  logic [HB_CHANNELS-1:0]  out_heartbeat_alert;
  logic [RSP_CHANNELS-1:0] out_responder_kill;
  logic                    out_frozen_event;

  logic                            psel    = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite  = 1'b0;
  logic [mchw_pkg::APB_ADDR_W-1:0] paddr   = '0;
  logic [mchw_pkg::APB_DATA_W-1:0] pwdata  = '0;
  logic [mchw_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;

  always #4 clk = ~clk;

  multi_channel_heartbeat_watchdog uut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_op                 (in_op),
    .in_channel            (in_channel),
    .in_now_ms             (in_now_ms),
    .in_monitors_alive     (in_monitors_alive),
    .in_responders_present (in_responders_present),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_monitor_restart   (out_monitor_restart),
    .out_heartbeat_alert   (out_heartbeat_alert),
    .out_responder_kill    (out_responder_kill),
    .out_frozen_event      (out_frozen_event),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  heartbeat_verdicts sb = new();

  // Traffic shaping, shared between the stimulus and the result sink.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_request   = 0;

  // Stimulus timeline: a running clock, a persistent responder population
  // and a step scale matched to the current limits.
  logic [mchw_pkg::TIME_W-1:0] sim_now      = '0;
  logic [RSP_CHANNELS-1:0]     present_mask = '0;
  logic [mchw_pkg::TIME_W-1:0] span         = 32'd10000;

  // --------------------------------------------------------------------------
  // Observe both channels at the clock edge; note inputs before results so
  // ordering would still hold if a result could return alongside its input.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_item(mchw_pkg::op_t'(in_op), in_channel, in_now_ms, in_monitors_alive,
                     in_responders_present);
      if (out_valid && out_ready)
        sb.check_result({out_monitor_restart, out_heartbeat_alert,
                         out_responder_kill, out_frozen_event});
    end
  end

  // Watchdog: give up when no transaction moves for too long.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result sink: random back-pressure, or a long hold-off when requested.
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        out_ready <= 1'b0;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------

  // Offer one transaction; idle first at random, then hold until accepted.
  // Valid is only lowered while idling, so back-to-back items never see a
  // lower-and-raise in the same step.
  task automatic offer_item(input mchw_pkg::op_t op, input logic [1:0] ch,
                            input logic [mchw_pkg::TIME_W-1:0] now,
                            input logic [MON_CHANNELS-1:0] alive,
                            input logic [RSP_CHANNELS-1:0] present);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid              <= 1'b1;
    in_op                 <= op;
    in_channel            <= ch;
    in_now_ms             <= now;
    in_monitors_alive     <= alive;
    in_responders_present <= present;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One APB transfer: setup cycle, then access until pready.
  task automatic apb_access(input logic write_en, input mchw_pkg::reg_idx_t idx,
                            input logic [mchw_pkg::APB_DATA_W-1:0] wdata,
                            output logic [mchw_pkg::APB_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write_en;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Write a limit, read it back, and mirror it in the scoreboard.
  task automatic program_limit(input mchw_pkg::reg_idx_t idx,
                               input logic [mchw_pkg::TIME_W-1:0] value);
    logic [mchw_pkg::APB_DATA_W-1:0] rd;
    apb_access(1'b1, idx, value, rd);
    apb_access(1'b0, idx, '0, rd);
    if (rd !== value) begin
      $error("register %s readback mismatch: expected %h, actual %h", idx.name(), value, rd);
      sb.errors++;
    end
    sb.set_limit(idx, value);
  endtask

  // Random traffic: mostly a coherent timeline with persistent responders,
  // the rest pure noise on every field.
  task automatic send_random_items(input int count);
    mchw_pkg::op_t               op;
    logic [1:0]                  ch;
    logic [mchw_pkg::TIME_W-1:0] now;
    logic [MON_CHANNELS-1:0]     alive;
    logic [RSP_CHANNELS-1:0]     present;
    int unsigned                 pick;
    logic [mchw_pkg::TIME_W-1:0] step;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 15) begin
        op      = mchw_pkg::op_t'($urandom_range(1));
        ch      = 2'($urandom_range(3));
        now     = $urandom();
        alive   = MON_CHANNELS'($urandom());
        present = RSP_CHANNELS'($urandom());
      end else begin
        // Advance time: short hops, hops near the limits, rare wild jumps.
        pick = $urandom_range(9);
        if (pick < 5) step = $urandom_range(span / 4);
        else if (pick < 9) step = $urandom_range(span + span / 4, span / 2);
        else step = $urandom();
        sim_now = sim_now + step;
        now     = ($urandom_range(99) < 3) ? '0 : sim_now;
        op      = ($urandom_range(99) < 35) ? mchw_pkg::OP_KICK : mchw_pkg::OP_CHECK;
        ch      = ($urandom_range(9) == 0) ? 2'(HB_CHANNELS) :
                                             2'($urandom_range(HB_CHANNELS - 1));
        alive   = ($urandom_range(99) < 70) ? '1 : MON_CHANNELS'($urandom());
        // Let responders come and go slowly so they live long enough to age.
        for (int b = 0; b < RSP_CHANNELS; b++) begin
          if ($urandom_range(9) == 0) present_mask[b] = ~present_mask[b];
        end
        present = present_mask;
      end
      offer_item(op, ch, now, alive, present);
    end
  endtask

  // One phase: drain, reprogram both limits, set the traffic mix, send.
  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input logic [mchw_pkg::TIME_W-1:0] timeout,
                           input logic [mchw_pkg::TIME_W-1:0] lifetime,
                           input int count, input bit hold_off, input bit mid_drain);
    wait_drained();
    program_limit(mchw_pkg::REG_HEARTBEAT_TIMEOUT, timeout);
    program_limit(mchw_pkg::REG_RESPONDER_LIFETIME, lifetime);
    span = (timeout > lifetime) ? timeout : lifetime;
    if (span == '0) span = 32'd16;
    else if (span > 32'h4000_0000) span = 32'h4000_0000;
    sim_now        = $urandom();
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    // Starve the sink while the sender keeps pushing, so the pipe backs up.
    if (hold_off) hold_request = HOLD_CYCLES;
    if (mid_drain) begin
      send_random_items(count / 2);
      wait_drained();
      send_random_items(count - count / 2);
    end else begin
      send_random_items(count);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, under the reset limits (timeout 2000, lifetime 10000).
    // Kick at time zero leaves the channel unarmed.
    offer_item(mchw_pkg::OP_KICK,  2'd0, 32'd0,     3'b111, 4'h0);
    offer_item(mchw_pkg::OP_CHECK, 2'd0, 32'd5000,  3'b111, 4'h0);
    // Kicks must ignore liveness and presence fields.
    offer_item(mchw_pkg::OP_KICK,  2'd0, 32'd100,   3'b000, 4'hF);
    offer_item(mchw_pkg::OP_KICK,  2'd1, 32'd100,   3'b101, 4'hA);
    offer_item(mchw_pkg::OP_KICK,  2'd2, 32'd1000,  3'b111, 4'h0);
    // Out-of-range channel: dropped, still returns an all-zero result.
    offer_item(mchw_pkg::OP_KICK,  2'(HB_CHANNELS), 32'd50, 3'b111, 4'hF);
    // Gap equal to the timeout does not alert; all monitors dead.
    offer_item(mchw_pkg::OP_CHECK, 2'd0, 32'd2100,  3'b000, 4'h0);
    // One past the limit alerts; channel field ignored on a check.
    offer_item(mchw_pkg::OP_CHECK, 2'(HB_CHANNELS), 32'd2101, 3'b111, 4'h0);
    // Fresh spawn: responders latch now and survive this check.
    offer_item(mchw_pkg::OP_CHECK, 2'd1, 32'd3001,  3'b110, 4'hF);
    // Age equal to lifetime survives; next millisecond kills.
    offer_item(mchw_pkg::OP_CHECK, 2'd2, 32'd13001, 3'b011, 4'hF);
    offer_item(mchw_pkg::OP_CHECK, 2'd0, 32'd13002, 3'b111, 4'h5);
    // Wrapping gap across 2^32.
    offer_item(mchw_pkg::OP_KICK,  2'd0, 32'hFFFF_FF00, 3'b111, 4'h0);
    offer_item(mchw_pkg::OP_CHECK, 2'd0, 32'h0000_0100, 3'b111, 4'h0);
    offer_item(mchw_pkg::OP_CHECK, 2'd0, 32'h0000_0800, 3'b111, 4'h0);
    // Latch at time zero keeps responders untracked.
    offer_item(mchw_pkg::OP_CHECK, 2'd0, 32'd0,     3'b111, 4'hF);
    offer_item(mchw_pkg::OP_CHECK, 2'd0, 32'd20000, 3'b111, 4'hF);
    // Extreme time: every responder far past its lifetime.
    offer_item(mchw_pkg::OP_CHECK, 2'd3, 32'hFFFF_FFFF, 3'b111, 4'hF);
    offer_item(mchw_pkg::OP_CHECK, 2'd0, 32'hFFFF_FFFF, 3'b000, 4'h0);

    // Random phases: idle %, stall %, timeout, lifetime, count, hold, drain.
    run_phase(0,  0,  32'd2000, 32'd10000, 250, 1'b1, 1'b0);
    run_phase(88, 0,  32'd0, 32'd0, 200, 1'b0, 1'b0);
    run_phase(0,  88, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 220, 1'b0, 1'b0);
    run_phase(21, 21, $urandom_range(5000, 1), $urandom_range(20000, 1), 250, 1'b0, 1'b1);
    run_phase(0,  21, 32'd1, 32'hFFFF_FFFF, 200, 1'b1, 1'b0);
    run_phase(21, 0,  $urandom(), $urandom(), 150, 1'b0, 1'b0);
    run_phase(21, 21, 32'd300, 32'd1500, 150, 1'b0, 1'b0);

    // Release back-pressure and let the pipe empty.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_drained();

    $display("Covered %0d transactions (%0d kicks, %0d checks) over eight limit settings",
             sb.items, sb.kicks, sb.checks);
    $display("Predicted %0d heartbeat alerts, %0d responder kills, %0d monitor restarts",
             sb.alerts, sb.kills, sb.restarts);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
